@@ rtl/lgr_pkg.sv @@
// shared types and constants of the lda gibbs topic resampler
package lgr_pkg;

    // widest index fields that an item can carry between the front and the back
    localparam int TOK_W   = 24;
    localparam int DOC_W   = 20;
    localparam int WORD_W  = 20;
    localparam int TOPIC_W = 10;
    localparam int KLIM_W  = 11;

    // count, weight and denominator term widths
    localparam int CNT_W = 17;
    localparam int WT_W  = 48;
    localparam int VB_W  = 37;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // configuration register indexes
    localparam logic [1:0] CFG_TOPICS = 2'd0;
    localparam logic [1:0] CFG_VOCAB  = 2'd1;
    localparam logic [1:0] CFG_ALPHA  = 2'd2;
    localparam logic [1:0] CFG_BETA   = 2'd3;

    // item commands
    localparam logic CMD_INIT     = 1'b0;
    localparam logic CMD_RESAMPLE = 1'b1;

    // classified item queued between front and back
    typedef struct packed {
        logic               cmd;
        logic [TOK_W-1:0]   tok;
        logic [DOC_W-1:0]   doc;
        logic [WORD_W-1:0]  word;
        logic [TOPIC_W-1:0] topic;
        logic [31:0]        frac;
    } t_item;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [KLIM_W-1:0] k_lim;
        logic [23:0]       alpha;
        logic [23:0]       beta;
        logic [VB_W-1:0]   vbeta;
    } t_cfg;

    // weight unit request and response
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] wc;
        logic [CNT_W-1:0] dc;
        logic [CNT_W-1:0] tc;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [WT_W-1:0] weight;
    } t_div_rsp;

    // back status
    typedef struct packed {
        logic clearing;
    } t_bstat;

endpackage

@@ rtl/lda_gibbs_topic_resampler_top.sv @@
// Collapsed Gibbs topic resampler for LDA. After reset the word-topic, doc-topic and topic
// total stores are zeroed by a clearing pass, during which no item is taken; configuration
// writes are taken at any time. In a resample each of the K topics in use goes through the
// shared weight unit (four 17x17 partial products and a 48-step bit-serial divide, the
// divide skipped when the weight saturates). The draw then scans the stored cumulative
// weights, stopping at the chosen one. The front takes no new item until its last one is
// pushed into the queue. A two-entry queue lets it take and prepare further items while
// the back works.
module lda_gibbs_topic_resampler_top #(
    parameter int MAX_TOPICS = 64,
    parameter int MAX_WORDS  = 4096,
    parameter int MAX_DOCS   = 1024,
    parameter int MAX_TOKENS = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [15:0] i_token_index,
    input  logic [9:0]  i_doc_index,
    input  logic [11:0] i_word_index,
    input  logic [5:0]  i_initial_topic,
    input  logic [31:0] i_random_fraction,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_topic,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    import lgr_pkg::*;

    logic [6:0]      r_topics;
    logic [12:0]     r_vocab;
    logic [23:0]     r_alpha;
    logic [23:0]     r_beta;
    logic [VB_W-1:0] r_vbeta;
    logic [VB_W-1:0] n_vbeta;
    t_cfg            cfg;
    t_item           f_item;
    t_item           q_head;
    logic            f_push;
    logic            q_full;
    logic            q_empty;
    logic            b_pop;
    t_div_req        div_req;
    t_div_rsp        div_rsp;
    t_bstat          b_stat;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_topics <= 7'd64;
            r_vocab  <= 13'd4096;
            r_alpha  <= 24'd0;
            r_beta   <= 24'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TOPICS: r_topics <= i_cfg_data[6:0];
                CFG_VOCAB:  r_vocab  <= i_cfg_data[12:0];
                CFG_ALPHA:  r_alpha  <= i_cfg_data;
                CFG_BETA:   r_beta   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // denominator term V*beta
    assign n_vbeta = r_vocab * r_beta;

    always_ff @(posedge i_clk) begin
        r_vbeta <= n_vbeta;
    end

    // topics in use clamped to 1..MAX_TOPICS
    always_comb begin
        if (r_topics == 7'd0) cfg.k_lim = KLIM_W'(1);
        else if (KLIM_W'(r_topics) > KLIM_W'(MAX_TOPICS)) cfg.k_lim = KLIM_W'(MAX_TOPICS);
        else cfg.k_lim = KLIM_W'(r_topics);
        cfg.alpha = r_alpha;
        cfg.beta  = r_beta;
        cfg.vbeta = r_vbeta;
    end

    lgr_front #(
        .MAX_DOCS   (MAX_DOCS),
        .MAX_WORDS  (MAX_WORDS),
        .MAX_TOKENS (MAX_TOKENS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_cmd             (i_cmd),
        .i_token_index     (i_token_index),
        .i_doc_index       (i_doc_index),
        .i_word_index      (i_word_index),
        .i_initial_topic   (i_initial_topic),
        .i_random_fraction (i_random_fraction),
        .i_cfg             (cfg),
        .i_clearing        (b_stat.clearing),
        .o_push            (f_push),
        .o_item            (f_item),
        .i_full            (q_full)
    );

    lgr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_item),
        .o_full  (q_full),
        .i_pop   (b_pop),
        .o_data  (q_head),
        .o_empty (q_empty)
    );

    lgr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    lgr_back #(
        .MAX_TOPICS (MAX_TOPICS),
        .MAX_DOCS   (MAX_DOCS),
        .MAX_WORDS  (MAX_WORDS),
        .MAX_TOKENS (MAX_TOKENS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (q_head),
        .i_empty   (q_empty),
        .o_pop     (b_pop),
        .i_cfg     (cfg),
        .o_div_req (div_req),
        .i_div_rsp (div_rsp),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_topic   (o_topic),
        .o_stat    (b_stat)
    );

endmodule

@@ rtl/lgr_fifo.sv @@
// two-entry item queue between front and back
module lgr_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lgr_pkg::t_item i_data,
    output logic           o_full,
    input  logic           i_pop,
    output lgr_pkg::t_item o_data,
    output logic           o_empty
);
    import lgr_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_data;
    end

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) r_wp <= ~r_wp;
            if (i_pop && !o_empty) r_rp <= ~r_rp;
            if ((i_push && !o_full) && !(i_pop && !o_empty)) r_cnt <= r_cnt + 2'd1;
            else if (!(i_push && !o_full) && (i_pop && !o_empty)) r_cnt <= r_cnt - 2'd1;
        end
    end

endmodule

@@ rtl/lgr_front.sv @@
// front: accepts items, reduces indices to the store depths and clamps the initial topic
module lgr_front #(
    parameter int MAX_DOCS   = 1024,
    parameter int MAX_WORDS  = 4096,
    parameter int MAX_TOKENS = 65536
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic           i_cmd,
    input  logic [15:0]    i_token_index,
    input  logic [9:0]     i_doc_index,
    input  logic [11:0]    i_word_index,
    input  logic [5:0]     i_initial_topic,
    input  logic [31:0]    i_random_fraction,
    input  lgr_pkg::t_cfg  i_cfg,
    input  logic           i_clearing,
    output logic           o_push,
    output lgr_pkg::t_item o_item,
    input  logic           i_full
);
    import lgr_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_RED  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]         r_state;
    logic [3:0]         r_s;
    logic               r_cmd;
    logic [15:0]        r_tok;
    logic [9:0]         r_doc;
    logic [11:0]        r_word;
    logic [TOPIC_W-1:0] r_topic;
    logic [31:0]        r_frac;
    logic               accept;
    logic [KLIM_W-1:0]  init_c;
    logic [15:0]        n_tok;
    logic [9:0]         n_doc;
    logic [11:0]        n_word;

    assign o_stall = (r_state != F_IDLE) || i_clearing;
    assign accept  = i_valid && !o_stall;
    assign o_push  = (r_state == F_PUSH) && !i_full;

    // initial topic clamped to the last topic in use
    assign init_c = (KLIM_W'(i_initial_topic) >= i_cfg.k_lim) ? (i_cfg.k_lim - 1'b1)
                                                              : KLIM_W'(i_initial_topic);

    // one shifted compare and subtract per cycle for each index
    always_comb begin
        n_tok  = r_tok;
        n_doc  = r_doc;
        n_word = r_word;
        if (32'(r_tok >> r_s) >= 32'(MAX_TOKENS)) n_tok = r_tok - (16'(MAX_TOKENS) << r_s);
        if (32'(r_doc >> r_s) >= 32'(MAX_DOCS)) n_doc = r_doc - (10'(MAX_DOCS) << r_s);
        if (32'(r_word >> r_s) >= 32'(MAX_WORDS)) n_word = r_word - (12'(MAX_WORDS) << r_s);
    end

    // queued item
    always_comb begin
        o_item.cmd   = r_cmd;
        o_item.tok   = TOK_W'(r_tok);
        o_item.doc   = DOC_W'(r_doc);
        o_item.word  = WORD_W'(r_word);
        o_item.topic = r_topic;
        o_item.frac  = r_frac;
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_cmd;
            r_tok   <= i_token_index;
            r_doc   <= i_doc_index;
            r_word  <= i_word_index;
            r_topic <= TOPIC_W'(init_c);
            r_frac  <= i_random_fraction;
        end else if (r_state == F_RED) begin
            r_tok  <= n_tok;
            r_doc  <= n_doc;
            r_word <= n_word;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_s     <= 4'd0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_s     <= 4'd15;
                        r_state <= F_RED;
                    end
                end
                F_RED: begin
                    if (r_s == 4'd0) r_state <= F_PUSH;
                    else r_s <= r_s - 4'd1;
                end
                F_PUSH: begin
                    if (!i_full) r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/lgr_div.sv @@
// weight unit: (wc+beta)(dc+alpha)/(tc+V*beta) by partial products and a bit-serial divide
module lgr_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lgr_pkg::t_cfg    i_cfg,
    input  lgr_pkg::t_div_req i_req,
    output lgr_pkg::t_div_rsp o_rsp
);
    import lgr_pkg::*;

    localparam logic [2:0] D_IDLE = 3'd0;
    localparam logic [2:0] D_MUL  = 3'd1;
    localparam logic [2:0] D_CHK  = 3'd2;
    localparam logic [2:0] D_DIV  = 3'd3;
    localparam logic [2:0] D_DONE = 3'd4;

    logic [2:0]      r_state;
    logic [5:0]      r_cnt;
    logic [33:0]     r_a;
    logic [33:0]     r_b;
    logic [37:0]     r_d;
    logic [67:0]     r_p;
    logic [37:0]     r_rem;
    logic [WT_W-1:0] r_q;
    logic [16:0]     a_h;
    logic [16:0]     b_h;
    logic [33:0]     prod;
    logic [67:0]     pp;
    logic [38:0]     trial;
    logic            ge;

    // one 17x17 partial product per cycle
    assign a_h  = r_cnt[0] ? r_a[33:17] : r_a[16:0];
    assign b_h  = r_cnt[1] ? r_b[33:17] : r_b[16:0];
    assign prod = a_h * b_h;

    always_comb begin
        unique case (r_cnt[1:0])
            2'd0:    pp = 68'(prod);
            2'd3:    pp = 68'(prod) << 34;
            default: pp = 68'(prod) << 17;
        endcase
    end

    // restoring divide step
    assign trial = {r_rem, r_p[47]};
    assign ge    = (trial >= {1'b0, r_d});

    assign o_rsp.done   = (r_state == D_DONE);
    assign o_rsp.weight = r_q;

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            D_IDLE: begin
                r_a <= 34'({i_req.wc, 16'b0}) + 34'(i_cfg.beta);
                r_b <= 34'({i_req.dc, 16'b0}) + 34'(i_cfg.alpha);
                r_d <= 38'({i_req.tc, 16'b0}) + 38'(i_cfg.vbeta);
                r_p <= '0;
            end
            D_MUL: r_p <= r_p + pp;
            D_CHK: begin
                if ((r_d == '0) || (38'(r_p[67:48]) >= r_d)) r_q <= '1;
                else r_rem <= 38'(r_p[67:48]);
            end
            D_DIV: begin
                if (ge) r_rem <= 38'(trial - {1'b0, r_d});
                else r_rem <= 38'(trial);
                r_q <= {r_q[WT_W-2:0], ge};
                r_p <= {r_p[66:0], 1'b0};
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_cnt   <= 6'd0;
        end else begin
            unique case (r_state)
                D_IDLE: begin
                    r_cnt <= 6'd0;
                    if (i_req.start) r_state <= D_MUL;
                end
                D_MUL: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd3) r_state <= D_CHK;
                end
                D_CHK: begin
                    r_cnt <= 6'd0;
                    if ((r_d == '0) || (38'(r_p[67:48]) >= r_d)) r_state <= D_DONE;
                    else r_state <= D_DIV;
                end
                D_DIV: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd47) r_state <= D_DONE;
                end
                D_DONE: r_state <= D_IDLE;
                default: r_state <= D_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/lgr_back.sv @@
// back: count stores, topic scan, cumulative draw and result register
module lgr_back #(
    parameter int MAX_TOPICS = 64,
    parameter int MAX_DOCS   = 1024,
    parameter int MAX_WORDS  = 4096,
    parameter int MAX_TOKENS = 65536
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lgr_pkg::t_item    i_head,
    input  logic              i_empty,
    output logic              o_pop,
    input  lgr_pkg::t_cfg     i_cfg,
    output lgr_pkg::t_div_req o_div_req,
    input  lgr_pkg::t_div_rsp i_div_rsp,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [5:0]        o_topic,
    output lgr_pkg::t_bstat   o_stat
);
    import lgr_pkg::*;

    localparam int KW   = $clog2(MAX_TOPICS);
    localparam int WW   = $clog2(MAX_WORDS);
    localparam int DW   = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;
    localparam int TOKW = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
    localparam int WAW  = WW + KW;
    localparam int DAW  = DW + KW;
    localparam int CLW  = (WAW > DAW) ? WAW : DAW;
    localparam int TOTW = WT_W + KW;
    localparam int RW   = 32 + TOTW;

    localparam logic [3:0] B_IDLE    = 4'd0;
    localparam logic [3:0] B_TOK     = 4'd1;
    localparam logic [3:0] B_DEC_WR  = 4'd2;
    localparam logic [3:0] B_SC_RD   = 4'd3;
    localparam logic [3:0] B_SC_LD   = 4'd4;
    localparam logic [3:0] B_SC_DIV  = 4'd5;
    localparam logic [3:0] B_RM0     = 4'd6;
    localparam logic [3:0] B_RM1     = 4'd7;
    localparam logic [3:0] B_SEL_RD  = 4'd8;
    localparam logic [3:0] B_SEL_CMP = 4'd9;
    localparam logic [3:0] B_INC_RD  = 4'd10;
    localparam logic [3:0] B_INC_WR  = 4'd11;

    // stores
    logic [CNT_W-1:0] m_wc  [2**WAW];
    logic [CNT_W-1:0] m_dc  [2**DAW];
    logic [CNT_W-1:0] m_tc  [2**KW];
    logic [KW-1:0]    m_tok [2**TOKW];
    logic [TOTW-1:0]  m_cum [2**KW];

    logic [3:0]       r_state;
    logic [3:0]       n_state;
    t_item            r_item;
    logic [KW-1:0]    r_k;
    logic [KW-1:0]    n_k;
    logic [KW-1:0]    r_t;
    logic [KW-1:0]    n_t;
    logic [KW-1:0]    r_old;
    logic [KW-1:0]    n_old;
    logic [TOTW-1:0]  r_total;
    logic [TOTW-1:0]  n_total;
    logic [RW-1:0]    r_rprod;
    logic [CLW:0]     r_clr;
    logic [CNT_W-1:0] r_wc_q;
    logic [CNT_W-1:0] r_dc_q;
    logic [CNT_W-1:0] r_tc_q;
    logic [KW-1:0]    r_tok_q;
    logic [TOTW-1:0]  r_cum_q;
    logic             r_out_valid;
    logic [5:0]       r_out_topic;

    logic             clearing;
    logic             last;
    logic             out_free;
    logic             pop;
    logic             cnt_re;
    logic             cnt_we;
    logic [KW-1:0]    rd_topic;
    logic [KW-1:0]    wr_topic;
    logic             wr_inc;
    logic [WAW-1:0]   wc_raddr;
    logic [WAW-1:0]   wc_waddr;
    logic [DAW-1:0]   dc_raddr;
    logic [DAW-1:0]   dc_waddr;
    logic [KW-1:0]    tc_waddr;
    logic [CNT_W-1:0] wc_wdata;
    logic [CNT_W-1:0] dc_wdata;
    logic [CNT_W-1:0] tc_wdata;
    logic             tok_we;
    logic [TOTW-1:0]  total_sum;
    logic [63:0]      rm_lo;
    logic [TOTW-1:0]  rm_hi;
    logic [TOTW-1:0]  r_hi;

    assign clearing  = !r_clr[CLW];
    assign last      = (KLIM_W'(r_k) == (i_cfg.k_lim - 1'b1));
    assign out_free  = !r_out_valid || !i_stall;
    assign o_pop     = pop;
    assign o_valid   = r_out_valid;
    assign o_topic   = r_out_topic;
    assign o_stat.clearing = clearing;

    assign o_div_req.start = (r_state == B_SC_LD);
    assign o_div_req.wc    = r_wc_q;
    assign o_div_req.dc    = r_dc_q;
    assign o_div_req.tc    = r_tc_q;

    assign total_sum = r_total + TOTW'(i_div_rsp.weight);

    // random fraction times total, in two partial products
    assign rm_lo = r_item.frac * r_total[31:0];
    assign rm_hi = r_item.frac * r_total[TOTW-1:32];
    assign r_hi  = r_rprod[RW-1:32];

    // count store addressing
    always_comb begin
        unique case (r_state)
            B_TOK:   rd_topic = r_tok_q;
            B_SC_RD: rd_topic = r_k;
            default: rd_topic = r_t;
        endcase
    end

    assign cnt_re   = (r_state == B_TOK) || (r_state == B_SC_RD) || (r_state == B_INC_RD);
    assign wr_inc   = (r_state == B_INC_WR);
    assign tok_we   = (r_state == B_INC_WR) && out_free;
    assign cnt_we   = clearing || (r_state == B_DEC_WR) || tok_we;
    assign wr_topic = (r_state == B_DEC_WR) ? r_old : r_t;
    assign wc_raddr = {r_item.word[WW-1:0], rd_topic};
    assign dc_raddr = {r_item.doc[DW-1:0], rd_topic};

    // write side: clearing pass, saturating decrement or increment
    always_comb begin
        if (clearing) begin
            wc_waddr = r_clr[WAW-1:0];
            dc_waddr = r_clr[DAW-1:0];
            tc_waddr = r_clr[KW-1:0];
            wc_wdata = '0;
            dc_wdata = '0;
            tc_wdata = '0;
        end else begin
            wc_waddr = {r_item.word[WW-1:0], wr_topic};
            dc_waddr = {r_item.doc[DW-1:0], wr_topic};
            tc_waddr = wr_topic;
            if (wr_inc) begin
                wc_wdata = (r_wc_q == COUNT_MAX) ? r_wc_q : r_wc_q + 1'b1;
                dc_wdata = (r_dc_q == COUNT_MAX) ? r_dc_q : r_dc_q + 1'b1;
                tc_wdata = (r_tc_q == COUNT_MAX) ? r_tc_q : r_tc_q + 1'b1;
            end else begin
                wc_wdata = (r_wc_q == '0) ? r_wc_q : r_wc_q - 1'b1;
                dc_wdata = (r_dc_q == '0) ? r_dc_q : r_dc_q - 1'b1;
                tc_wdata = (r_tc_q == '0) ? r_tc_q : r_tc_q - 1'b1;
            end
        end
    end

    // count memories
    always_ff @(posedge i_clk) begin
        if (cnt_we) m_wc[wc_waddr] <= wc_wdata;
        if (cnt_re) r_wc_q <= m_wc[wc_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) m_dc[dc_waddr] <= dc_wdata;
        if (cnt_re) r_dc_q <= m_dc[dc_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) m_tc[tc_waddr] <= tc_wdata;
        if (cnt_re) r_tc_q <= m_tc[rd_topic];
    end

    // token topic memory
    always_ff @(posedge i_clk) begin
        if (tok_we) m_tok[r_item.tok[TOKW-1:0]] <= r_t;
        if (pop) r_tok_q <= m_tok[i_head.tok[TOKW-1:0]];
    end

    // cumulative weight memory
    always_ff @(posedge i_clk) begin
        if ((r_state == B_SC_DIV) && i_div_rsp.done) m_cum[r_k] <= total_sum;
        if (r_state == B_SEL_RD) r_cum_q <= m_cum[r_k];
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_t     = r_t;
        n_old   = r_old;
        n_total = r_total;
        pop     = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!clearing && !i_empty) begin
                    pop = 1'b1;
                    if (i_head.cmd == CMD_RESAMPLE) begin
                        n_state = B_TOK;
                    end else begin
                        n_t     = i_head.topic[KW-1:0];
                        n_state = B_INC_RD;
                    end
                end
            end
            B_TOK: begin
                n_old   = r_tok_q;
                n_state = B_DEC_WR;
            end
            B_DEC_WR: begin
                n_k     = '0;
                n_total = '0;
                n_state = B_SC_RD;
            end
            B_SC_RD: n_state = B_SC_LD;
            B_SC_LD: n_state = B_SC_DIV;
            B_SC_DIV: begin
                if (i_div_rsp.done) begin
                    n_total = total_sum;
                    if (last) begin
                        n_state = B_RM0;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = B_SC_RD;
                    end
                end
            end
            B_RM0: n_state = B_RM1;
            B_RM1: begin
                n_k     = '0;
                n_state = B_SEL_RD;
            end
            B_SEL_RD: n_state = B_SEL_CMP;
            B_SEL_CMP: begin
                if ((r_cum_q > r_hi) || last) begin
                    n_t     = r_k;
                    n_state = B_INC_RD;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = B_SEL_RD;
                end
            end
            B_INC_RD: n_state = B_INC_WR;
            B_INC_WR: begin
                if (out_free) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (pop) r_item <= i_head;
        r_k     <= n_k;
        r_t     <= n_t;
        r_old   <= n_old;
        r_total <= n_total;
        if (r_state == B_RM0) r_rprod <= RW'(rm_lo);
        else if (r_state == B_RM1) r_rprod <= r_rprod + {rm_hi, 32'b0};
        if (tok_we) r_out_topic <= 6'(r_t);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clearing) r_clr <= r_clr + 1'b1;
            if (tok_we) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_stall) r_out_valid <= 1'b0;
        end
    end

    // no item work while the count stores are being cleared
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> (r_state == B_IDLE))
        else $error("item work during clearing pass");

    // weight unit started only from the scan load step
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_SC_DIV) |-> !o_div_req.start)
        else $error("weight unit restarted while busy");

    // scan index stays inside the topics in use
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == B_SC_DIV) || (r_state == B_SEL_CMP)) |-> (KLIM_W'(r_k) < i_cfg.k_lim))
        else $error("topic index beyond topics in use");

    // finishing an item always leaves a result waiting
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_we |=> r_out_valid)
        else $error("finished item without result");

endmodule
